@@ design/tec_pkg.sv @@
// Package for the terminal escape cursor engine.
// Holds the result beat type, command codes and default screen size.
// No dependencies.
package tec_pkg;

  localparam int COLUMNS_DEF = 40;
  localparam int ROWS_DEF    = 8;

  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_ERASE = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] cell_col;
    logic [2:0] cell_row;
    logic [7:0] glyph;
    logic [1:0] attribute;
  } tec_result_t;

endpackage

@@ design/tec_core.sv @@
// Parser and cursor state for the terminal escape cursor engine.
// Holds cursor, phase, arguments and attribute; builds at most one result per byte.
// Depends on tec_pkg.
module tec_core #(
  parameter int COLUMNS = tec_pkg::COLUMNS_DEF,
  parameter int ROWS    = tec_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          char_code,
  output logic                has_result,
  output tec_pkg::tec_result_t result
);
  import tec_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  localparam logic [2:0] PH_TEXT = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_ARG1 = 3'd2;
  localparam logic [2:0] PH_ARG2 = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_SO  = 8'h0E;
  localparam logic [7:0] CH_SI  = 8'h0F;
  localparam logic [7:0] GLYPH_SPACE = 8'h20;

  logic [CW-1:0] cursor_col, cursor_col_next;
  logic [RW-1:0] cursor_row, cursor_row_next;
  logic [2:0]    parse_phase, parse_phase_next;
  logic [7:0]    first_arg, first_arg_next;
  logic [7:0]    second_arg, second_arg_next;
  logic [1:0]    text_attr, text_attr_next;

  logic          is_digit;
  logic [7:0]    first_acc, second_acc;
  logic [8:0]    row9, col9, arg9, row_sum, col_sum;
  logic [RW-1:0] row_up, row_down, row_goto, row_wrap_next, row_wrap_prev;
  logic [CW-1:0] col_left, col_right, col_goto;
  logic [7:0]    goto_r, goto_c;
  logic [7:0]    col8, row8;
  logic [1:0]    attr2;

  always_comb begin
    is_digit   = (char_code >= 8'h30) && (char_code <= 8'h39);
    first_acc  = (first_arg << 3) + (first_arg << 1) + {4'b0000, char_code[3:0]};
    second_acc = (second_arg << 3) + (second_arg << 1) + {4'b0000, char_code[3:0]};

    row9 = 9'(cursor_row);
    col9 = 9'(cursor_col);
    arg9 = {1'b0, first_arg};
    row_sum = row9 + arg9;
    col_sum = col9 + arg9;
    row_up    = (row9 < arg9) ? '0 : RW'(row9 - arg9);
    row_down  = (row_sum >= 9'(ROWS)) ? ROW_LAST : RW'(row_sum);
    col_left  = (col9 < arg9) ? '0 : CW'(col9 - arg9);
    col_right = (col_sum >= 9'(COLUMNS)) ? COL_LAST : CW'(col_sum);

    goto_r = (first_arg != 8'd0) ? first_arg - 8'd1 : 8'd0;
    goto_c = (second_arg != 8'd0) ? second_arg - 8'd1 : 8'd0;
    row_goto = (9'(goto_r) >= 9'(ROWS)) ? ROW_LAST : RW'(goto_r);
    col_goto = (9'(goto_c) >= 9'(COLUMNS)) ? COL_LAST : CW'(goto_c);

    row_wrap_next = (cursor_row == ROW_LAST) ? '0 : cursor_row + RW'(1);
    row_wrap_prev = (cursor_row == '0) ? ROW_LAST : cursor_row - RW'(1);

    attr2 = (first_arg == 8'd0) ? 2'b00 : text_attr;
    if (second_arg == 8'd1) begin
      attr2 = attr2 | 2'b01;
    end else if (second_arg == 8'd7) begin
      attr2 = attr2 | 2'b10;
    end

    col8 = 8'(cursor_col);
    row8 = 8'(cursor_row);
  end

  always_comb begin
    cursor_col_next  = cursor_col;
    cursor_row_next  = cursor_row;
    parse_phase_next = parse_phase;
    first_arg_next   = first_arg;
    second_arg_next  = second_arg;
    text_attr_next   = text_attr;
    has_result       = 1'b0;
    result.command   = CMD_DRAW;
    result.cell_col  = col8[5:0];
    result.cell_row  = row8[2:0];
    result.glyph     = GLYPH_SPACE;
    result.attribute = 2'b00;

    if (char_code == CH_ESC) begin
      parse_phase_next = PH_ESC;
    end else begin
      unique case (parse_phase)
        PH_ESC: begin
          first_arg_next  = 8'd0;
          second_arg_next = 8'd0;
          if (char_code == "[") begin
            parse_phase_next = PH_ARG1;
          end else if (char_code == "(" || char_code == ")") begin
            parse_phase_next = PH_SKIP;
          end else begin
            parse_phase_next = PH_TEXT;
            if (char_code == "c") begin
              cursor_col_next = '0;
              cursor_row_next = '0;
              has_result      = 1'b1;
              result.command  = CMD_CLEAR;
              result.cell_col = 6'd0;
              result.cell_row = 3'd0;
            end
          end
        end
        PH_ARG1: begin
          if (char_code == ";") begin
            parse_phase_next = PH_ARG2;
          end else if (char_code == "?") begin
            parse_phase_next = PH_ARG1;
          end else if (is_digit) begin
            first_arg_next = first_acc;
          end else begin
            parse_phase_next = PH_TEXT;
            case (char_code)
              "H": begin
                cursor_col_next = '0;
                cursor_row_next = '0;
              end
              "m": if (first_arg == 8'd0) text_attr_next = 2'b00;
              "A": cursor_row_next = row_up;
              "B": cursor_row_next = row_down;
              "D": cursor_col_next = col_left;
              "C": cursor_col_next = col_right;
              "J": begin
                cursor_col_next = '0;
                cursor_row_next = '0;
                has_result      = 1'b1;
                result.command  = CMD_CLEAR;
                result.cell_col = 6'd0;
                result.cell_row = 3'd0;
              end
              "K": begin
                has_result     = 1'b1;
                result.command = CMD_ERASE;
              end
              default: ;
            endcase
          end
        end
        PH_ARG2: begin
          if (is_digit) begin
            second_arg_next = second_acc;
          end else begin
            parse_phase_next = PH_TEXT;
            if (char_code == "H") begin
              cursor_row_next = row_goto;
              cursor_col_next = col_goto;
            end else if (char_code == "m") begin
              text_attr_next = attr2;
            end
          end
        end
        PH_TEXT: begin
          case (char_code)
            CH_CR: cursor_col_next = '0;
            CH_LF: begin
              cursor_col_next = '0;
              cursor_row_next = row_wrap_next;
            end
            CH_BEL, CH_SO, CH_SI: ;
            CH_BS: begin
              has_result = 1'b1;
              if (cursor_col != '0) begin
                cursor_col_next = cursor_col - CW'(1);
              end else begin
                cursor_col_next = COL_LAST;
                cursor_row_next = row_wrap_prev;
              end
            end
            default: begin
              has_result       = 1'b1;
              result.glyph     = char_code;
              result.attribute = text_attr;
              if (cursor_col == COL_LAST) begin
                cursor_col_next = '0;
                cursor_row_next = row_wrap_next;
              end else begin
                cursor_col_next = cursor_col + CW'(1);
              end
            end
          endcase
        end
        default: parse_phase_next = PH_TEXT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_row  <= '0;
      parse_phase <= PH_TEXT;
      first_arg   <= 8'd0;
      second_arg  <= 8'd0;
      text_attr   <= 2'b00;
    end else if (step) begin
      cursor_col  <= cursor_col_next;
      cursor_row  <= cursor_row_next;
      parse_phase <= parse_phase_next;
      first_arg   <= first_arg_next;
      second_arg  <= second_arg_next;
      text_attr   <= text_attr_next;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cursor_col <= COL_LAST) else $error("cursor column off screen");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cursor_row <= ROW_LAST) else $error("cursor row off screen");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    parse_phase <= PH_SKIP) else $error("parser phase undefined");
  a_esc_enter: assert property (@(posedge clk) disable iff (rst)
    step && (char_code == CH_ESC) |=> parse_phase == PH_ESC)
    else $error("escape did not restart sequence");

endmodule

@@ design/tec_out_reg.sv @@
// Result register for the terminal escape cursor engine.
// Holds one result beat until the downstream side takes it.
// Depends on tec_pkg.
module tec_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tec_pkg::tec_result_t load_data,
  input  logic                ready,
  output logic                valid,
  output logic                can_take,
  output tec_pkg::tec_result_t data
);
  import tec_pkg::*;

  assign can_take = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

@@ design/terminal_escape_cursor_engine.sv @@
// Terminal escape cursor engine: takes one terminal byte per beat and returns at most one
// screen command (draw cell, clear screen, erase to end of row) per byte. A byte goes into
// an input register, is decoded combinationally against the cursor and parser state, and
// its command lands in a result register: one byte per cycle sustained unless a waiting
// result stalls the input. Bytes with no command leave no result beat. While a result
// waits and the held byte makes another command, in_ready follows out_ready combinationally.
module terminal_escape_cursor_engine #(
  parameter int COLUMNS = tec_pkg::COLUMNS_DEF,
  parameter int ROWS    = tec_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] command,
  output logic [5:0] cell_col,
  output logic [2:0] cell_row,
  output logic [7:0] glyph,
  output logic [1:0] attribute
);
  import tec_pkg::*;

  logic        in_full;
  logic [7:0]  in_char;
  logic        step;
  logic        has_result;
  logic        can_take;
  tec_result_t core_result;
  tec_result_t out_data;

  assign step     = in_full && (!has_result || can_take);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= char_code;
    end
  end

  tec_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (in_char),
    .has_result(has_result),
    .result    (core_result)
  );

  tec_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && has_result),
    .load_data(core_result),
    .ready    (out_ready),
    .valid    (out_valid),
    .can_take (can_take),
    .data     (out_data)
  );

  assign command   = out_data.command;
  assign cell_col  = out_data.cell_col;
  assign cell_row  = out_data.cell_row;
  assign glyph     = out_data.glyph;
  assign attribute = out_data.attribute;

endmodule
